// ----- hw/rtl/lslp_pkg.sv -----
`timescale 1ns / 1ps
// lslp_pkg: shared constants, types and the arctangent table of the label placer
// depends on nothing

package lslp_pkg;

  // default configuration of the placer
  localparam int COORD_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // fixed field widths
  localparam int LABEL_W     = 16;
  localparam int LABEL_FRAC  = 8;
  localparam int ANGLE_W     = 15;

  // cordic scaling, angle accumulator and rounding to Q2.13
  localparam int PRESCALE_SH = 20;
  localparam int Z_W         = 32;
  localparam int ROUND_HALF  = 65536;
  localparam int ANGLE_SH    = 17;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 15'sd12868;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -15'sd12868;

  // path element kinds
  typedef enum logic [1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_CURVE = 2'd3
  } lslp_mode_t;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_SQUARE,
    ST_SUM,
    ST_LAUNCH,
    ST_WAIT,
    ST_UPDATE,
    ST_REPORT
  } lslp_state_t;

  // atan(2^-i) in Q.30 radians
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    case (idx)
      0:       return 32'sd843314857;
      1:       return 32'sd497837830;
      2:       return 32'sd263043837;
      3:       return 32'sd133525159;
      4:       return 32'sd67021687;
      5:       return 32'sd33543515;
      6:       return 32'sd16775851;
      7:       return 32'sd8388438;
      8:       return 32'sd4194283;
      9:       return 32'sd2097149;
      10:      return 32'sd1048576;
      11:      return 32'sd524288;
      12:      return 32'sd262144;
      13:      return 32'sd131072;
      14:      return 32'sd65536;
      15:      return 32'sd32768;
      16:      return 32'sd16384;
      17:      return 32'sd8192;
      18:      return 32'sd4096;
      19:      return 32'sd2048;
      20:      return 32'sd1024;
      21:      return 32'sd512;
      22:      return 32'sd256;
      23:      return 32'sd128;
      24:      return 32'sd64;
      25:      return 32'sd32;
      26:      return 32'sd16;
      27:      return 32'sd8;
      28:      return 32'sd4;
      29:      return 32'sd2;
      30:      return 32'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/lslp_in_if.sv -----
`timescale 1ns / 1ps
// lslp_in_if: path element channel, valid/ready with element kind, end point and last flag
// depends on lslp_pkg

interface lslp_in_if #(
  parameter int COORD_WIDTH = lslp_pkg::COORD_WIDTH_DEF
) ();
  import lslp_pkg::*;

  logic                          valid;
  logic                          ready;
  lslp_mode_t                    mode;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last;

  modport source (output valid, mode, point_x, point_y, last, input ready);
  modport sink   (input valid, mode, point_x, point_y, last, output ready);
endinterface

// ----- hw/rtl/lslp_out_if.sv -----
`timescale 1ns / 1ps
// lslp_out_if: placement result channel, valid/ready with found flag, midpoint and angle
// depends on lslp_pkg

interface lslp_out_if #(
  parameter int COORD_WIDTH = lslp_pkg::COORD_WIDTH_DEF
) ();
  import lslp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          found;
  logic signed [COORD_WIDTH-1:0] best_x;
  logic signed [COORD_WIDTH-1:0] best_y;
  logic signed [ANGLE_W-1:0]     angle;

  modport source (output valid, found, best_x, best_y, angle, input ready);
  modport sink   (input valid, found, best_x, best_y, angle, output ready);
endinterface

// ----- hw/rtl/lslp_sqrt_cell.sv -----
`timescale 1ns / 1ps
// lslp_sqrt_cell: one restoring square-root step, one root bit per cell, registered
// depends on lslp_pkg (default width only)

module lslp_sqrt_cell #(
  parameter int ROOT_W = lslp_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [ROOT_W+1:0]     in_rem,
  input  logic [ROOT_W-1:0]     in_root,
  input  logic [2*ROOT_W-1:0]   in_rad,
  output logic                  out_valid,
  output logic [ROOT_W+1:0]     out_rem,
  output logic [ROOT_W-1:0]     out_root,
  output logic [2*ROOT_W-1:0]   out_rad
);
  localparam int REM_W = ROOT_W + 2;
  localparam int RAD_W = 2 * ROOT_W;

  logic              valid_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RAD_W-1:0]  rad_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  // bring down two radicand bits and try 4*root+1
  always_comb begin
    rem_sh   = {in_rem[REM_W-3:0], in_rad[RAD_W-1:RAD_W-2]};
    trial    = {in_root, 2'b01};
    take     = (rem_sh >= trial);
    rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    root_nxt = {in_root[ROOT_W-2:0], take};
  end

  // token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // step data
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= {in_rad[RAD_W-3:0], 2'b00};
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_rad   = rad_r;

endmodule

// ----- hw/rtl/lslp_cordic_cell.sv -----
`timescale 1ns / 1ps
// lslp_cordic_cell: one vectoring rotation step with its fixed arctangent, registered
// depends on lslp_pkg (arctangent table, accumulator width)

module lslp_cordic_cell #(
  parameter int STEP = 0,
  parameter int CW   = lslp_pkg::COORD_WIDTH_DEF + lslp_pkg::PRESCALE_SH + 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [CW-1:0]            in_x,
  input  logic signed [CW-1:0]            in_y,
  input  logic signed [lslp_pkg::Z_W-1:0] in_z,
  output logic                            out_valid,
  output logic signed [CW-1:0]            out_x,
  output logic signed [CW-1:0]            out_y,
  output logic signed [lslp_pkg::Z_W-1:0] out_z
);
  import lslp_pkg::*;

  localparam logic signed [Z_W-1:0] STEP_ANGLE = atan_q30(STEP);

  logic                  valid_r;
  logic signed [CW-1:0]  x_r;
  logic signed [CW-1:0]  y_r;
  logic signed [Z_W-1:0] z_r;

  logic signed [CW-1:0]  xs;
  logic signed [CW-1:0]  ys;
  logic signed [CW-1:0]  x_nxt;
  logic signed [CW-1:0]  y_nxt;
  logic signed [Z_W-1:0] z_nxt;

  // rotate toward y = 0, floor shifts
  always_comb begin
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
    if (in_y > 0) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + STEP_ANGLE;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - STEP_ANGLE;
    end
  end

  // token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // step data
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule

// ----- hw/rtl/longest_segment_label_placer.sv -----
`timescale 1ns / 1ps
// longest_segment_label_placer: picks the longest path segment beyond the label width
// depends on lslp_pkg, lslp_in_if, lslp_out_if, lslp_sqrt_cell, lslp_cordic_cell
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        mode, point_x, point_y, last
//   out_ch   out  valid/ready        found, best_x, best_y, angle
//   cfg_     in   cfg_we, no wait    cfg_wdata = label_width
//
// move and curve elements are taken in the idle state; a line or close element steps
// through the abs, square, sum and launch states and then waits for the row of
// square-root cells, one root bit per cell, and the row of cordic cells beside it.
// an element marked last passes through the report state to hand the result to the output register.
// synchronous active-low reset clears the path state and the label width.
// the next element is taken while a result waits in the output register; a second
// result stalls the block until the first transaction completes.

module longest_segment_label_placer #(
  parameter int COORD_WIDTH  = lslp_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = lslp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lslp_pkg::LABEL_W-1:0] cfg_wdata,
  lslp_in_if.sink                      in_ch,
  lslp_out_if.source                   out_ch
);
  import lslp_pkg::*;

  localparam int C      = COORD_WIDTH;
  localparam int ROOT_W = C + 1;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int CW     = C + PRESCALE_SH + 3;
  localparam int THR_W  = ((ROOT_W > LABEL_W + LABEL_FRAC) ? ROOT_W : LABEL_W + LABEL_FRAC) + 1;

  // sequencer
  lslp_state_t state_r, state_nxt;
  logic        in_fire;
  logic        launch;
  logic        report_go;

  // configuration and path state
  logic [LABEL_W-1:0]      label_width_r;
  logic signed [C-1:0]     start_x_r, start_y_r, cur_x_r, cur_y_r;
  logic [ROOT_W-1:0]       best_excess_r;
  logic signed [C-1:0]     best_mid_x_r, best_mid_y_r;
  logic signed [ANGLE_W-1:0] best_angle_r;

  // segment in flight
  logic signed [C:0]       dx_r, dy_r;
  logic signed [C-1:0]     mid_x_r, mid_y_r;
  logic                    last_r;
  logic [C-1:0]            ax_r, ay_r;
  logic signed [CW-1:0]    cx0_r, cy0_r;
  logic [2*C-1:0]          sqx_r, sqy_r;
  logic [RAD_W-1:0]        sum_r;
  logic [ROOT_W-1:0]       len_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    sq_done_r, cd_done_r;

  // output register
  logic                    out_valid_r;
  logic                    out_found_r;
  logic signed [C-1:0]     out_x_r, out_y_r;
  logic signed [ANGLE_W-1:0] out_angle_r;

  // segment end point, differences and midpoint
  logic signed [C-1:0]     end_x, end_y;
  logic signed [C:0]       dx_new, dy_new, hs_x, hs_y;
  logic signed [C:0]       dx_abs, dy_abs, y_sel;

  // compare and angle rounding
  logic [THR_W-1:0]        len_ext, thr, exc_full;
  logic                    win;
  logic signed [Z_W:0]     z_rnd, q_full;
  logic signed [ANGLE_W-1:0] angle_val;

  // cell rows
  logic                    sq_v    [0:ROOT_W];
  logic [REM_W-1:0]        sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]       sq_root [0:ROOT_W];
  logic [RAD_W-1:0]        sq_rad  [0:ROOT_W];
  logic                    cd_v    [0:CORDIC_STEPS];
  logic signed [CW-1:0]    cd_x    [0:CORDIC_STEPS];
  logic signed [CW-1:0]    cd_y    [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]   cd_z    [0:CORDIC_STEPS];

  // segment geometry at accept
  always_comb begin
    end_x  = (in_ch.mode == MODE_CLOSE) ? start_x_r : in_ch.point_x;
    end_y  = (in_ch.mode == MODE_CLOSE) ? start_y_r : in_ch.point_y;
    dx_new = {cur_x_r[C-1], cur_x_r} - {end_x[C-1], end_x};
    dy_new = {cur_y_r[C-1], cur_y_r} - {end_y[C-1], end_y};
    hs_x   = {cur_x_r[C-1], cur_x_r} + {end_x[C-1], end_x};
    hs_y   = {cur_y_r[C-1], cur_y_r} + {end_y[C-1], end_y};
  end

  // magnitudes and cordic start vector
  always_comb begin
    dx_abs = dx_r[C] ? -dx_r : dx_r;
    dy_abs = dy_r[C] ? -dy_r : dy_r;
    y_sel  = dx_r[C] ? -dy_r : dy_r;
  end

  // winner test and angle rounding
  always_comb begin
    len_ext  = THR_W'(len_r);
    thr      = THR_W'({label_width_r, {LABEL_FRAC{1'b0}}}) + THR_W'(best_excess_r);
    win      = (len_ext > thr);
    exc_full = len_ext - THR_W'({label_width_r, {LABEL_FRAC{1'b0}}});
    z_rnd    = {z_r[Z_W-1], z_r} + (Z_W+1)'(ROUND_HALF);
    q_full   = z_rnd >>> ANGLE_SH;
    if (dx_r == '0) begin
      angle_val = ANGLE_MIN;
    end else if (q_full > ANGLE_MAX) begin
      angle_val = ANGLE_MAX;
    end else if (q_full < ANGLE_MIN) begin
      angle_val = ANGLE_MIN;
    end else begin
      angle_val = q_full[ANGLE_W-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_fire   = 1'b0;
    launch    = 1'b0;
    report_go = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_fire = in_ch.valid;
        if (in_ch.valid) begin
          if (in_ch.mode == MODE_LINE || in_ch.mode == MODE_CLOSE) begin
            state_nxt = ST_ABS;
          end else if (in_ch.last) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_ABS:    state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_LAUNCH;
      ST_LAUNCH: begin
        launch    = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sq_done_r && cd_done_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = last_r ? ST_REPORT : ST_IDLE;
      ST_REPORT: begin
        report_go = !out_valid_r || out_ch.ready;
        if (report_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // label width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_width_r <= '0;
    end else if (cfg_we) begin
      label_width_r <= cfg_wdata;
    end
  end

  // path state: start, current point and best segment
  always_ff @(posedge clk) begin
    if (!rst_n || report_go) begin
      start_x_r     <= '0;
      start_y_r     <= '0;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      best_excess_r <= '0;
      best_mid_x_r  <= '0;
      best_mid_y_r  <= '0;
      best_angle_r  <= '0;
    end else begin
      if (in_fire) begin
        case (in_ch.mode)
          MODE_MOVE: begin
            start_x_r <= in_ch.point_x;
            start_y_r <= in_ch.point_y;
            cur_x_r   <= in_ch.point_x;
            cur_y_r   <= in_ch.point_y;
          end
          MODE_LINE, MODE_CLOSE, MODE_CURVE: begin
            cur_x_r <= end_x;
            cur_y_r <= end_y;
          end
          default: begin
            cur_x_r <= cur_x_r;
          end
        endcase
      end
      if (state_r == ST_UPDATE && win) begin
        best_excess_r <= exc_full[ROOT_W-1:0];
        best_mid_x_r  <= mid_x_r;
        best_mid_y_r  <= mid_y_r;
        best_angle_r  <= angle_val;
      end
    end
  end

  // segment pipeline ahead of the cell rows and capture of their results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dx_r    <= dx_new;
      dy_r    <= dy_new;
      mid_x_r <= hs_x[C:1];
      mid_y_r <= hs_y[C:1];
      last_r  <= in_ch.last;
    end
    if (state_r == ST_ABS) begin
      ax_r  <= dx_abs[C-1:0];
      ay_r  <= dy_abs[C-1:0];
      cx0_r <= {{(CW-C-PRESCALE_SH){1'b0}}, dx_abs[C-1:0], {PRESCALE_SH{1'b0}}};
      cy0_r <= {{(CW-C-1-PRESCALE_SH){y_sel[C]}}, y_sel, {PRESCALE_SH{1'b0}}};
    end
    if (state_r == ST_SQUARE) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
    end
    if (state_r == ST_SUM) begin
      sum_r <= RAD_W'(sqx_r) + RAD_W'(sqy_r);
    end
    if (sq_v[ROOT_W]) begin
      len_r <= sq_root[ROOT_W];
    end
    if (cd_v[CORDIC_STEPS]) begin
      z_r <= cd_z[CORDIC_STEPS];
    end
  end

  // completion flags of the two cell rows
  always_ff @(posedge clk) begin
    if (!rst_n || launch) begin
      sq_done_r <= 1'b0;
      cd_done_r <= 1'b0;
    end else begin
      if (sq_v[ROOT_W]) begin
        sq_done_r <= 1'b1;
      end
      if (cd_v[CORDIC_STEPS]) begin
        cd_done_r <= 1'b1;
      end
    end
  end

  // square-root cell row
  assign sq_v[0]    = launch;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = sum_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    lslp_sqrt_cell #(
      .ROOT_W (ROOT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_rem    (sq_rem[k]),
      .in_root   (sq_root[k]),
      .in_rad    (sq_rad[k]),
      .out_valid (sq_v[k+1]),
      .out_rem   (sq_rem[k+1]),
      .out_root  (sq_root[k+1]),
      .out_rad   (sq_rad[k+1])
    );
  end

  // cordic cell row
  assign cd_v[0] = launch;
  assign cd_x[0] = cx0_r;
  assign cd_y[0] = cy0_r;
  assign cd_z[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    lslp_cordic_cell #(
      .STEP (k),
      .CW   (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cd_v[k]),
      .in_x      (cd_x[k]),
      .in_y      (cd_y[k]),
      .in_z      (cd_z[k]),
      .out_valid (cd_v[k+1]),
      .out_x     (cd_x[k+1]),
      .out_y     (cd_y[k+1]),
      .out_z     (cd_z[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (report_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_go) begin
      out_found_r <= (best_excess_r != '0);
      out_x_r     <= best_mid_x_r;
      out_y_r     <= best_mid_y_r;
      out_angle_r <= best_angle_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.best_x = out_x_r;
  assign out_ch.best_y = out_y_r;
  assign out_ch.angle  = out_angle_r;

  // row outputs only show up while the sequencer waits for them
  a_sqrt_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[ROOT_W] |-> state_r == ST_WAIT)
    else $error("square-root row finished outside the wait state");

  a_cordic_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cd_v[CORDIC_STEPS] |-> state_r == ST_WAIT)
    else $error("cordic row finished outside the wait state");

  // a report clears the path state
  a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    report_go |=> (best_excess_r == '0 && cur_x_r == '0 && start_y_r == '0))
    else $error("path state not cleared after a report");

  // an empty result carries zero fields
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_x_r == '0 && out_y_r == '0 && out_angle_r == '0))
    else $error("result without a segment has nonzero fields");

  // reported angle stays within plus or minus pi/2
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_angle_r <= ANGLE_MAX && out_angle_r >= ANGLE_MIN))
    else $error("reported angle out of range");

endmodule

// ----- tb/sv/tb_longest_segment_label_placer.sv -----
`timescale 1ns / 1ps
// tb_longest_segment_label_placer: self-checking bench for the longest segment label placer
// drives path elements and label widths, predicts each placement and checks it on the output
// depends on lslp_pkg, lslp_in_if, lslp_out_if and longest_segment_label_placer

module tb_longest_segment_label_placer;
  import lslp_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int STEPS       = CORDIC_STEPS_DEF;
  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = 48;
  localparam int STALL_LIMIT = 5000;

  localparam logic signed [CW-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] COORD_MIN = 24'sh800000;

  // atan(2^-i) in Q.30 radians, one entry per rotation step
  localparam longint ARCTAN_Q30 [16] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543515,
    16775851, 8388438, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };

  typedef struct packed {
    lslp_mode_t              mode;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic                    last;
  } path_elem_t;

  typedef struct packed {
    logic                    found;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANGLE_W-1:0] angle;
  } placement_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LABEL_W-1:0] cfg_wdata;

  lslp_in_if  #(.COORD_WIDTH(CW)) element_if ();
  lslp_out_if #(.COORD_WIDTH(CW)) placement_if ();

  longest_segment_label_placer #(
    .COORD_WIDTH (CW),
    .CORDIC_STEPS(STEPS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (element_if),
    .out_ch   (placement_if)
  );

  path_elem_t element_q[$];
  placement_t placement_q[$];

  int         fail_count;
  logic       in_took;
  logic       calm;
  int         hold_token;
  int         hold_seen;
  int         hold_left;
  int         stuck_cycles;

  // predicted block state
  logic [LABEL_W-1:0]      label_width_q;
  longint                  trk_start_x, trk_start_y, trk_cur_x, trk_cur_y;
  longint unsigned         trk_best_excess;
  longint                  trk_mid_x, trk_mid_y;
  logic signed [ANGLE_W-1:0] trk_angle;

  path_elem_t              drv_elem;
  placement_t              want, got;

  // clock and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    element_if.valid = 1'b0;
    element_if.mode = MODE_MOVE;
    element_if.point_x = '0;
    element_if.point_y = '0;
    element_if.last = 1'b0;
    placement_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // segment length, excess over the label and, for a new best, midpoint and angle
  task automatic measure_segment(input longint ex, input longint ey);
    longint          dx, dy, ax, ay, x, y, z, xs, ys, q;
    longint unsigned sq, len, root_try, label_len;
    dx = trk_cur_x - ex;
    dy = trk_cur_y - ey;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = ax * ax + ay * ay;
    len = 0;
    for (int b = 31; b >= 0; b--) begin
      root_try = len | (64'd1 << b);
      if (root_try * root_try <= sq) len = root_try;
    end
    label_len = longint'(label_width_q) << LABEL_FRAC;
    if (len > label_len && (len - label_len) > trk_best_excess) begin
      trk_best_excess = len - label_len;
      trk_mid_x = (trk_cur_x + ex) >>> 1;
      trk_mid_y = (trk_cur_y + ey) >>> 1;
      if (dx == 0) begin
        trk_angle = ANGLE_MIN;
      end else begin
        // vectoring rotation toward the x axis, right half plane only
        x = ax <<< PRESCALE_SH;
        y = ((dx < 0) ? -dy : dy) <<< PRESCALE_SH;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_Q30[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_Q30[i];
          end
        end
        q = (z + ROUND_HALF) >>> ANGLE_SH;
        if (q > ANGLE_MAX) q = ANGLE_MAX;
        if (q < ANGLE_MIN) q = ANGLE_MIN;
        trk_angle = q[ANGLE_W-1:0];
      end
    end
    trk_cur_x = ex;
    trk_cur_y = ey;
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // monitor: tracks the label width, predicts on input transactions, checks output ones
  always @(posedge clk) begin
    in_took <= rst_n && element_if.valid && element_if.ready;
    if (!rst_n) begin
      label_width_q = '0;
      trk_start_x = 0; trk_start_y = 0; trk_cur_x = 0; trk_cur_y = 0;
      trk_best_excess = 0; trk_mid_x = 0; trk_mid_y = 0; trk_angle = '0;
    end else begin
      if (cfg_we) label_width_q = cfg_wdata;
      if (element_if.valid && element_if.ready) begin
        case (element_if.mode)
          MODE_MOVE: begin
            trk_start_x = element_if.point_x;
            trk_start_y = element_if.point_y;
            trk_cur_x = element_if.point_x;
            trk_cur_y = element_if.point_y;
          end
          MODE_LINE:  measure_segment(element_if.point_x, element_if.point_y);
          MODE_CLOSE: measure_segment(trk_start_x, trk_start_y);
          default: begin
            trk_cur_x = element_if.point_x;
            trk_cur_y = element_if.point_y;
          end
        endcase
        if (element_if.last) begin
          want.found = (trk_best_excess > 0);
          want.x = trk_mid_x[CW-1:0];
          want.y = trk_mid_y[CW-1:0];
          want.angle = trk_angle;
          placement_q = {placement_q, want};
          trk_start_x = 0; trk_start_y = 0; trk_cur_x = 0; trk_cur_y = 0;
          trk_best_excess = 0; trk_mid_x = 0; trk_mid_y = 0; trk_angle = '0;
        end
      end
      if (placement_if.valid && placement_if.ready) begin
        got.found = placement_if.found;
        got.x = placement_if.best_x;
        got.y = placement_if.best_y;
        got.angle = placement_if.angle;
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected placement, expected none actual found=%0d x=%0d y=%0d angle=%0d",
                   $time, got.found, got.x, got.y, got.angle);
          fail_count++;
        end else begin
          want = placement_q.pop_front();
          check_field("found", want.found, got.found);
          check_field("best_x", want.x, got.x);
          check_field("best_y", want.y, got.y);
          check_field("angle", want.angle, got.angle);
        end
      end
    end
  end

  // driver: offers queued path elements, idling at random unless calm
  always @(negedge clk) begin
    if (!rst_n) begin
      element_if.valid <= 1'b0;
    end else if (!element_if.valid || in_took) begin
      if (element_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        drv_elem = element_q.pop_front();
        element_if.valid   <= 1'b1;
        element_if.mode    <= drv_elem.mode;
        element_if.point_x <= drv_elem.x;
        element_if.point_y <= drv_elem.y;
        element_if.last    <= drv_elem.last;
      end else begin
        element_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random ready, plus a long hold-off whenever a new one is requested
  always @(negedge clk) begin
    if (!rst_n) begin
      placement_if.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      placement_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      placement_if.ready <= 1'b0;
    end else begin
      placement_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((element_if.valid && element_if.ready) || (placement_if.valid && placement_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("longest_segment_label_placer test failed");
    $finish;
  end

  task automatic queue_element(input lslp_mode_t m, input logic signed [CW-1:0] x,
                               input logic signed [CW-1:0] y, input logic l);
    path_elem_t e;
    e.mode = m;
    e.x = x;
    e.y = y;
    e.last = l;
    element_q = {element_q, e};
  endtask

  // coordinate with a size class: 0 within 16 pixels, 1 within 1024, 2 anywhere
  function automatic logic signed [CW-1:0] pick_coord(input int span);
    int          roll;
    int          v;
    logic [31:0] raw;
    roll = $urandom_range(0, 99);
    raw = $urandom();
    if (roll < 3) return COORD_MAX;
    if (roll < 6) return COORD_MIN;
    case (span)
      0:       v = int'(raw[12:0]) - 4096;
      1:       v = int'(raw[18:0]) - 262144;
      default: v = int'(raw);
    endcase
    return v[CW-1:0];
  endfunction

  // well-formed paths with random content, mixed with random noise elements
  task automatic queue_paths(input int n_items, input int span, input int noise_pct);
    int         made, segs, pick, sp;
    lslp_mode_t m;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        m = lslp_mode_t'($urandom_range(0, 3));
        queue_element(m, pick_coord(2), pick_coord(2), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        sp = $urandom_range(0, span);
        segs = $urandom_range(1, 8);
        if ($urandom_range(0, 9) != 0) begin
          queue_element(MODE_MOVE, pick_coord(sp), pick_coord(sp), 1'b0);
          made++;
        end
        for (int k = 0; k < segs; k++) begin
          pick = $urandom_range(0, 99);
          m = (pick < 65) ? MODE_LINE : (pick < 80) ? MODE_CLOSE :
              (pick < 92) ? MODE_CURVE : MODE_MOVE;
          queue_element(m, pick_coord(sp), pick_coord(sp), k == segs - 1);
          made++;
        end
      end
    end
  endtask

  // wait for the block to drain, then for its element latency
  task automatic settle();
    while (element_q.size() != 0 || element_if.valid || placement_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_width(input logic [LABEL_W-1:0] w);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    fail_count = 0;
    calm = 1'b0;
    hold_token = 0;
    hold_seen = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, zero label width
    write_width(16'd0);
    queue_element(MODE_LINE, 24'sd25600, -24'sd12800, 1'b0);   // segment from reset point
    queue_element(MODE_MOVE, COORD_MAX, COORD_MAX, 1'b0);
    queue_element(MODE_LINE, COORD_MIN, COORD_MIN, 1'b0);       // longest diagonal
    queue_element(MODE_CURVE, 24'sd100, 24'sd100, 1'b0);        // curve only moves
    queue_element(MODE_LINE, 24'sd100, 24'sd5000, 1'b0);        // vertical segment
    queue_element(MODE_LINE, 24'sd100, 24'sd5000, 1'b0);        // zero length
    queue_element(MODE_CLOSE, 24'sd0, 24'sd0, 1'b0);
    queue_element(MODE_LINE, -24'sd300, 24'sd5000, 1'b1);
    queue_element(MODE_LINE, 24'sd2560, 24'sd0, 1'b0);          // equal excess, first kept
    queue_element(MODE_LINE, 24'sd0, 24'sd0, 1'b0);
    queue_element(MODE_CURVE, 24'sd5, 24'sd5, 1'b1);
    queue_element(MODE_MOVE, 24'sd0, 24'sd0, 1'b1);             // nothing found
    queue_element(MODE_MOVE, -24'sd1000, -24'sd1000, 1'b0);
    queue_element(MODE_LINE, -24'sd1000, 24'sd3000, 1'b0);
    queue_element(MODE_LINE, 24'sd4000, -24'sd1000, 1'b0);
    queue_element(MODE_CLOSE, 24'sd0, 24'sd0, 1'b1);            // close as last element
    queue_element(MODE_CLOSE, 24'sd0, 24'sd0, 1'b1);            // close on cleared state

    // directed, widest label
    write_width(16'hFFFF);
    queue_element(MODE_MOVE, COORD_MIN, COORD_MIN, 1'b0);
    queue_element(MODE_LINE, COORD_MAX, COORD_MAX, 1'b0);
    queue_element(MODE_LINE, COORD_MIN, COORD_MAX, 1'b1);
    queue_element(MODE_MOVE, COORD_MIN, 24'sd0, 1'b0);
    queue_element(MODE_LINE, 24'sh7FFF00, 24'sd0, 1'b1);        // length equals label

    // random phases
    write_width(16'($urandom_range(1, 30)));
    calm = 1'b1;
    queue_paths(400, 0, 5);
    settle();
    calm = 1'b0;

    write_width(16'($urandom_range(0, 2000)));
    queue_paths(400, 1, 8);
    hold_token++;

    write_width(16'hFFFF);
    queue_paths(250, 2, 8);

    write_width(16'($urandom()));
    queue_paths(300, 2, 8);
    hold_token++;

    write_width(16'd0);
    queue_paths(250, 2, 40);

    write_width(16'($urandom_range(0, 12)));
    queue_paths(250, 1, 10);

    settle();
    if (fail_count == 0 && placement_q.size() == 0)
      $display("longest_segment_label_placer test passed");
    else
      $display("longest_segment_label_placer test failed");
    $finish;
  end

endmodule
